// File: rtl/core/dual_beacon_rssi_median_outlier_filter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual beacon RSSI median filter
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_BEACON_RSSI_MEDIAN_OUTLIER_FILTER_ASSERT_SVH
`define DUAL_BEACON_RSSI_MEDIAN_OUTLIER_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define DBRMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define DBRMF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DBRMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DBRMF_ASSERT(lbl, prop, msg)
`define DBRMF_ASSERT_IMPL(lbl, ante, cons, msg)
`define DBRMF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/dbrmf_pkg.sv
// ----------------------------------------------------------------------------
// dbrmf_pkg
// Types, register codes, reset values and arithmetic helpers of the filter.
// ----------------------------------------------------------------------------
package dbrmf_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef logic signed [7:0] level_t;
  typedef logic [1:0]        class_t;
  typedef logic [15:0]       ident_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStationId   = 3'd0,
    CfgFirstMajor  = 3'd1,
    CfgFirstMinor  = 3'd2,
    CfgSecondMajor = 3'd3,
    CfgSecondMinor = 3'd4,
    CfgRejectThr   = 3'd5
  } cfg_reg_e;

  localparam logic [7:0] StationIdRst   = 8'd1;
  localparam ident_t     FirstMajorRst  = 16'd1;
  localparam ident_t     FirstMinorRst  = 16'd1;
  localparam ident_t     SecondMajorRst = 16'd1;
  localparam ident_t     SecondMinorRst = 16'd2;
  localparam logic [7:0] RejectThrRst   = 8'd5;

  typedef struct packed {
    ident_t beacon_major;
    ident_t beacon_minor;
    level_t signal_level;
    class_t nearness;
    logic   scan_end;
  } beacon_t;

  typedef struct packed {
    logic [7:0] station_tag;
    level_t     mean_level;
    class_t     closest_class;
    logic [1:0] accepted_count;
  } result_t;

  typedef struct packed {
    logic   got;
    level_t smoothed;
    class_t cls;
  } beacon_sum_t;

  typedef struct packed {
    logic       emit;
    level_t     mean_level;
    class_t     closest_class;
    logic [1:0] accepted_count;
  } verdict_t;

  function automatic logic [8:0] abs_diff(input level_t a, input level_t b);
    logic signed [8:0] d;
    d = {a[7], a} - {b[7], b};
    return d[8] ? 9'(-d) : 9'(d);
  endfunction

  function automatic level_t half_sum(input level_t a, input level_t b);
    logic signed [8:0] s;
    logic signed [8:0] q;
    s = {a[7], a} + {b[7], b};
    q = s >>> 1;
    if (s[8] && s[0]) begin
      q = q + 9'sd1;
    end
    return q[7:0];
  endfunction

endpackage

// File: rtl/core/dbrmf_in_if.sv
// ----------------------------------------------------------------------------
// dbrmf_in_if
// Beacon report channel: valid/ready handshake with the report fields.
// ----------------------------------------------------------------------------
interface dbrmf_in_if;
  logic                valid;
  logic                ready;
  logic [15:0]         beacon_major;
  logic [15:0]         beacon_minor;
  logic signed [7:0]   signal_level;
  logic [1:0]          nearness;
  logic                scan_end;

  modport source (
    output valid, beacon_major, beacon_minor, signal_level, nearness, scan_end,
    input  ready
  );
  modport sink (
    input  valid, beacon_major, beacon_minor, signal_level, nearness, scan_end,
    output ready
  );
endinterface

// File: rtl/core/dbrmf_out_if.sv
// ----------------------------------------------------------------------------
// dbrmf_out_if
// Station result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface dbrmf_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        station_tag;
  logic signed [7:0] mean_level;
  logic [1:0]        closest_class;
  logic [1:0]        accepted_count;

  modport source (
    output valid, station_tag, mean_level, closest_class, accepted_count,
    input  ready
  );
  modport sink (
    input  valid, station_tag, mean_level, closest_class, accepted_count,
    output ready
  );
endinterface

// File: rtl/core/dual_beacon_rssi_median_outlier_filter.sv
// ----------------------------------------------------------------------------
// dual_beacon_rssi_median_outlier_filter
// Median-smoothed RSSI of two configured beacons with outlier rejection.
// ----------------------------------------------------------------------------
// Usage:
//   beacon_in carries one scan report per beat; a beat with scan_end closes
//   the scan. result_out carries at most one station result per scan, loaded
//   into the result register when the closing report leaves the input register.
//   The cfg port writes one register per cycle with cfg_we_i high; write it
//   only while no report is held inside the block.
//   A report waits in the input register until it is evaluated; the result of
//   a closing report is then held in the result register until it is taken.
//   Throughput: one report per cycle while result_out does not stall; the median
//   and rejection logic sits between the input register and the result register.
//   Reset clears the seen flags, both history fill counts, the prior average
//   and both valid registers, and loads the register reset values.
//   When result_out stalls, the held result stays put; one more report is
//   taken into the input register and then beacon_in.ready drops until the
//   result is taken.
// ----------------------------------------------------------------------------
`include "dual_beacon_rssi_median_outlier_filter_assert.svh"

module dual_beacon_rssi_median_outlier_filter #(
  parameter int unsigned HISTORY_DEPTH = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  dbrmf_in_if.sink                           beacon_in,
  dbrmf_out_if.source                        result_out,
  input  logic                               cfg_we_i,
  input  logic [dbrmf_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dbrmf_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic [7:0]        station_id_q, reject_thr_q;
  dbrmf_pkg::ident_t first_major_q, first_minor_q, second_major_q, second_minor_q;

  logic               in_valid_q;
  dbrmf_pkg::beacon_t item_q;
  logic               advance, proc, scan_done, out_load;

  logic               first_seen_q, second_seen_q;
  dbrmf_pkg::level_t  first_level_q, second_level_q;
  dbrmf_pkg::class_t  first_class_q, second_class_q;
  logic               m1, m2;

  dbrmf_pkg::beacon_sum_t first_sum, second_sum;
  dbrmf_pkg::level_t      first_smoothed, second_smoothed;
  dbrmf_pkg::verdict_t    verdict;

  dbrmf_pkg::level_t  prior_q;
  logic               out_valid_q;
  dbrmf_pkg::result_t result_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_id_q   <= dbrmf_pkg::StationIdRst;
      first_major_q  <= dbrmf_pkg::FirstMajorRst;
      first_minor_q  <= dbrmf_pkg::FirstMinorRst;
      second_major_q <= dbrmf_pkg::SecondMajorRst;
      second_minor_q <= dbrmf_pkg::SecondMinorRst;
      reject_thr_q   <= dbrmf_pkg::RejectThrRst;
    end else if (cfg_we_i) begin
      unique case (dbrmf_pkg::cfg_reg_e'(cfg_idx_i))
        dbrmf_pkg::CfgStationId:   station_id_q   <= cfg_data_i[7:0];
        dbrmf_pkg::CfgFirstMajor:  first_major_q  <= cfg_data_i;
        dbrmf_pkg::CfgFirstMinor:  first_minor_q  <= cfg_data_i;
        dbrmf_pkg::CfgSecondMajor: second_major_q <= cfg_data_i;
        dbrmf_pkg::CfgSecondMinor: second_minor_q <= cfg_data_i;
        dbrmf_pkg::CfgRejectThr:   reject_thr_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Input register
  assign advance         = !out_valid_q || result_out.ready;
  assign proc            = in_valid_q && advance;
  assign scan_done       = proc && item_q.scan_end;
  assign beacon_in.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (beacon_in.valid && beacon_in.ready) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beacon_in.valid && beacon_in.ready) begin
      item_q.beacon_major <= beacon_in.beacon_major;
      item_q.beacon_minor <= beacon_in.beacon_minor;
      item_q.signal_level <= beacon_in.signal_level;
      item_q.nearness     <= beacon_in.nearness;
      item_q.scan_end     <= beacon_in.scan_end;
    end
  end

  // Beacon match and latched reports
  assign m1 = (item_q.beacon_major == first_major_q) && (item_q.beacon_minor == first_minor_q);
  assign m2 = !m1 && (item_q.beacon_major == second_major_q) &&
              (item_q.beacon_minor == second_minor_q);

  always_comb begin
    first_sum.got       = first_seen_q || m1;
    first_sum.cls       = m1 ? item_q.nearness : first_class_q;
    first_sum.smoothed  = first_smoothed;
    second_sum.got      = second_seen_q || m2;
    second_sum.cls      = m2 ? item_q.nearness : second_class_q;
    second_sum.smoothed = second_smoothed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_seen_q   <= 1'b0;
      second_seen_q  <= 1'b0;
      first_level_q  <= '0;
      second_level_q <= '0;
      first_class_q  <= '0;
      second_class_q <= '0;
    end else if (proc) begin
      if (m1) begin
        first_level_q <= item_q.signal_level;
        first_class_q <= item_q.nearness;
      end
      if (m2) begin
        second_level_q <= item_q.signal_level;
        second_class_q <= item_q.nearness;
      end
      if (item_q.scan_end) begin
        first_seen_q  <= 1'b0;
        second_seen_q <= 1'b0;
      end else begin
        first_seen_q  <= first_seen_q || m1;
        second_seen_q <= second_seen_q || m2;
      end
    end
  end

  dbrmf_history #(
    .Depth (HISTORY_DEPTH)
  ) u_first_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (scan_done && first_sum.got),
    .level_i    (m1 ? item_q.signal_level : first_level_q),
    .smoothed_o (first_smoothed)
  );

  dbrmf_history #(
    .Depth (HISTORY_DEPTH)
  ) u_second_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (scan_done && second_sum.got),
    .level_i    (m2 ? item_q.signal_level : second_level_q),
    .smoothed_o (second_smoothed)
  );

  dbrmf_select u_select (
    .thr_i     (reject_thr_q),
    .prior_i   (prior_q),
    .first_i   (first_sum),
    .second_i  (second_sum),
    .verdict_o (verdict)
  );

  assign out_load = scan_done && verdict.emit;

  // Prior average and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        prior_q     <= verdict.mean_level;
        out_valid_q <= 1'b1;
      end else if (result_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_q.station_tag    <= station_id_q;
      result_q.mean_level     <= verdict.mean_level;
      result_q.closest_class  <= verdict.closest_class;
      result_q.accepted_count <= verdict.accepted_count;
    end
  end

  assign result_out.valid          = out_valid_q;
  assign result_out.station_tag    = result_q.station_tag;
  assign result_out.mean_level     = result_q.mean_level;
  assign result_out.closest_class  = result_q.closest_class;
  assign result_out.accepted_count = result_q.accepted_count;

  `DBRMF_ASSERT_IMPL(a_load_on_scan_end, out_load, in_valid_q && advance && item_q.scan_end,
    "result loaded without a closing report")
  `DBRMF_ASSERT_NEXT(a_seen_cleared, scan_done, !first_seen_q && !second_seen_q,
    "seen flags survive the end of a scan")
  `DBRMF_ASSERT_NEXT(a_prior_hold, !out_load, $stable(prior_q),
    "prior average moved without a result")
  `DBRMF_ASSERT_NEXT(a_item_hold, in_valid_q && !advance, in_valid_q && $stable(item_q),
    "held report lost while the result stalls")
  `DBRMF_ASSERT(a_count_range,
    !out_valid_q || result_q.accepted_count == 2'd1 || result_q.accepted_count == 2'd2,
    "result with an impossible accepted count")

endmodule

// File: rtl/core/dbrmf_history.sv
// ----------------------------------------------------------------------------
// dbrmf_history
// Level history of one beacon with the median of its nonzero entries.
// ----------------------------------------------------------------------------
module dbrmf_history #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dbrmf_pkg::level_t   level_i,
  output dbrmf_pkg::level_t   smoothed_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  dbrmf_pkg::level_t hist_q [Depth];
  dbrmf_pkg::level_t hist_d [Depth];
  dbrmf_pkg::level_t shifted [Depth];
  logic [CntW-1:0]   fill_q, fill_d;
  logic              full;

  logic [Depth-1:0]  live;
  logic [CntW-1:0]   rank [Depth];
  logic [CntW-1:0]   count;
  logic [CntW-1:0]   k_hi, k_lo;
  dbrmf_pkg::level_t hi_val, lo_val;

  always_comb begin
    full = (fill_q == CntW'(Depth));
    for (int i = 0; i < Depth - 1; i++) begin
      shifted[i] = hist_q[i + 1];
    end
    shifted[Depth-1] = level_i;
    fill_d = fill_q;
    for (int i = 0; i < Depth; i++) begin
      hist_d[i] = hist_q[i];
    end
    if (push_i) begin
      if (full) begin
        for (int i = 0; i < Depth; i++) begin
          hist_d[i] = shifted[i];
        end
      end else begin
        for (int i = 0; i < Depth; i++) begin
          if (fill_q == CntW'(i)) begin
            hist_d[i] = level_i;
          end
        end
        fill_d = fill_q + CntW'(1);
      end
    end
  end

  always_comb begin
    count = '0;
    for (int i = 0; i < Depth; i++) begin
      live[i] = (CntW'(i) < fill_d) && (hist_d[i] != 8'sd0);
      count   = count + CntW'(live[i]);
    end
    for (int i = 0; i < Depth; i++) begin
      rank[i] = '0;
      for (int j = 0; j < Depth; j++) begin
        if (live[j] && ((hist_d[j] < hist_d[i]) || ((hist_d[j] == hist_d[i]) && (j < i)))) begin
          rank[i] = rank[i] + CntW'(1);
        end
      end
    end
    k_hi   = count >> 1;
    k_lo   = k_hi - CntW'(1);
    hi_val = '0;
    lo_val = '0;
    for (int i = 0; i < Depth; i++) begin
      if (live[i] && (rank[i] == k_hi)) begin
        hi_val = hi_val | hist_d[i];
      end
      if (live[i] && (rank[i] == k_lo)) begin
        lo_val = lo_val | hist_d[i];
      end
    end
    if (count == '0) begin
      smoothed_o = '0;
    end else if (count[0]) begin
      smoothed_o = hi_val;
    end else begin
      smoothed_o = dbrmf_pkg::half_sum(hi_val, lo_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      hist_q[i] <= hist_d[i];
    end
  end

endmodule

// File: rtl/core/dbrmf_select.sv
// ----------------------------------------------------------------------------
// dbrmf_select
// Outlier rejection of both smoothed levels, averaging and closest class.
// ----------------------------------------------------------------------------
module dbrmf_select (
  input  logic [7:0]             thr_i,
  input  dbrmf_pkg::level_t      prior_i,
  input  dbrmf_pkg::beacon_sum_t first_i,
  input  dbrmf_pkg::beacon_sum_t second_i,
  output dbrmf_pkg::verdict_t    verdict_o
);

  logic no_prior, pass1, pass2, rescue, acc1, acc2, c1_ok, c2_ok;

  always_comb begin
    no_prior = (prior_i == 8'sd0);
    pass1    = no_prior || (dbrmf_pkg::abs_diff(first_i.smoothed, prior_i) <= {1'b0, thr_i});
    pass2    = no_prior || (dbrmf_pkg::abs_diff(second_i.smoothed, prior_i) <= {1'b0, thr_i});
    rescue   = first_i.got && second_i.got && !pass1 && !pass2 &&
               (dbrmf_pkg::abs_diff(first_i.smoothed, second_i.smoothed) <= {1'b0, thr_i});
    acc1     = (first_i.got && pass1) || rescue;
    acc2     = (second_i.got && pass2) || rescue;
    c1_ok    = acc1 && (first_i.cls != 2'd0);
    c2_ok    = acc2 && (second_i.cls != 2'd0);

    verdict_o.emit = acc1 || acc2;
    if (acc1 && acc2) begin
      verdict_o.mean_level     = dbrmf_pkg::half_sum(first_i.smoothed, second_i.smoothed);
      verdict_o.accepted_count = 2'd2;
    end else if (acc1) begin
      verdict_o.mean_level     = first_i.smoothed;
      verdict_o.accepted_count = 2'd1;
    end else begin
      verdict_o.mean_level     = second_i.smoothed;
      verdict_o.accepted_count = 2'd1;
    end

    priority if (c1_ok && c2_ok) begin
      verdict_o.closest_class = (first_i.cls < second_i.cls) ? first_i.cls : second_i.cls;
    end else if (c1_ok) begin
      verdict_o.closest_class = first_i.cls;
    end else if (c2_ok) begin
      verdict_o.closest_class = second_i.cls;
    end else begin
      verdict_o.closest_class = 2'd0;
    end
  end

endmodule
